// ===== hw/rtl/wgm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants for the wildcard glob matcher: action codes,
// pattern symbol codes and the control bundle broadcast to the cell row.
// ----------------------------------------------------------------------------
package wgm_pkg;

    // number of pattern cells in the row
    localparam int PATTERN_MAX = 32;
    // symbol width as carried on the port and held in a cell
    localparam int SYM_W = 16;

    // special pattern symbols
    localparam logic [SYM_W-1:0] SYM_STAR = SYM_W'(42);
    localparam logic [SYM_W-1:0] SYM_ANY  = SYM_W'(63);

    // transaction action codes
    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } act_t;

    // control broadcast to every cell for one accepted transaction
    typedef struct packed {
        logic             clear;
        logic             append;
        logic             text;
        logic             finish;
        logic [SYM_W-1:0] sym;
    } cell_ctrl_t;

endpackage : wgm_pkg
`default_nettype wire

// ===== hw/rtl/wgm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: holds a pattern symbol, its in-use flag and the live
// bit of the position. Star closure, advance and end-of-pattern detection
// are exchanged with the neighboring cells.
// ----------------------------------------------------------------------------
module wgm_cell
    import wgm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       origin,
    input  wire logic       left_active,
    input  wire logic       left_carry,
    input  wire logic       left_adv,
    output logic            active,
    output logic            carry_out,
    output logic            adv_out,
    output logic            end_hit
);

    logic             active_reg;
    logic             active_next;
    logic             live_reg;
    logic             live_next;
    logic [SYM_W-1:0] sym_reg;

    logic closed;
    logic is_tail;
    logic is_star;
    logic sym_hit;

    // closed live bit: own live bit plus star closure from the left
    assign closed  = live_reg | left_carry;
    assign is_tail = left_active & ~active_reg;
    assign is_star = (sym_reg == SYM_STAR);
    assign sym_hit = (sym_reg == SYM_ANY) | (sym_reg == ctrl.sym);

    // neighbor outputs
    assign active    = active_reg;
    assign carry_out = closed & active_reg & is_star;
    assign adv_out   = closed & active_reg & ~is_star & sym_hit;
    assign end_hit   = closed & is_tail;

    // next in-use flag and live bit
    always_comb
    begin
        active_next = active_reg;
        live_next   = live_reg;
        if (ctrl.clear)
        begin
            active_next = 1'b0;
            live_next   = origin;
        end
        else if (ctrl.append)
        begin
            if (is_tail)
            begin
                active_next = 1'b1;
            end
        end
        else if (ctrl.text)
        begin
            live_next = (closed & active_reg & is_star) | left_adv;
        end
        else if (ctrl.finish)
        begin
            live_next = origin;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            live_reg   <= origin;
        end
        else
        begin
            active_reg <= active_next;
            live_reg   <= live_next;
        end
    end

    // pattern symbol, written when this cell takes the appended symbol
    always_ff @(posedge clk)
    begin
        if (ctrl.append && is_tail)
        begin
            sym_reg <= ctrl.sym;
        end
    end

endmodule : wgm_cell
`default_nettype wire

// ===== hw/rtl/wildcard_glob_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Glob matcher ('*' and '?') over a symbol stream, built as a row of pattern
// cells that update all live positions in parallel every cycle.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle of any action while results drain.
// Result: the result of an end-of-text transaction is shown in the cycle after
//   acceptance, from the output register.
// The rate is set by the cell row updating all positions at once, with star
//   closure rippling combinationally through the cells.
// Reset: empty pattern, overflow flag low, only position zero live, no
//   result pending; pattern symbols hold no reset value.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher
    import wgm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire logic [1:0]       action,
    input  wire logic [SYM_W-1:0] symbol,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output logic                  matched,
    output logic                  pattern_too_long
);

    logic       accept;
    act_t       act;
    cell_ctrl_t ctrl;

    logic [PATTERN_MAX-1:0] active_vec;
    logic [PATTERN_MAX-1:0] carry_vec;
    logic [PATTERN_MAX-1:0] adv_vec;
    logic [PATTERN_MAX-1:0] end_vec;

    logic live_last_reg;
    logic live_last_next;
    logic overflow_reg;
    logic overflow_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic matched_reg;
    logic too_long_reg;

    logic closed_last;
    logic hit;

    // input handshake: take a transaction unless a result is stuck
    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;
    assign act       = act_t'(action);

    // control broadcast to the row
    always_comb
    begin
        ctrl.clear  = 1'b0;
        ctrl.append = 1'b0;
        ctrl.text   = 1'b0;
        ctrl.finish = 1'b0;
        ctrl.sym    = symbol;
        if (accept)
        begin
            unique case (act)
                ACT_CLEAR:  ctrl.clear  = 1'b1;
                ACT_APPEND: ctrl.append = 1'b1;
                ACT_TEXT:   ctrl.text   = 1'b1;
                ACT_END:    ctrl.finish = 1'b1;
                default:    ctrl.clear  = 1'b0;
            endcase
        end
    end

    // row of pattern cells
    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++)
        begin : g_cell
            logic left_active;
            logic left_carry;
            logic left_adv;
            if (g == 0)
            begin : g_first
                assign left_active = 1'b1;
                assign left_carry  = 1'b0;
                assign left_adv    = 1'b0;
            end
            else
            begin : g_rest
                assign left_active = active_vec[g-1];
                assign left_carry  = carry_vec[g-1];
                assign left_adv    = adv_vec[g-1];
            end
            wgm_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .origin      ((g == 0) ? 1'b1 : 1'b0),
                .left_active (left_active),
                .left_carry  (left_carry),
                .left_adv    (left_adv),
                .active      (active_vec[g]),
                .carry_out   (carry_vec[g]),
                .adv_out     (adv_vec[g]),
                .end_hit     (end_vec[g])
            );
        end
    endgenerate

    // final position past the last cell
    assign closed_last = live_last_reg | carry_vec[PATTERN_MAX-1];
    assign hit = (|end_vec) | (closed_last & active_vec[PATTERN_MAX-1]);

    // next state of final position, overflow flag and result valid
    always_comb
    begin
        live_last_next = live_last_reg;
        overflow_next  = overflow_reg;
        if (ctrl.clear)
        begin
            live_last_next = 1'b0;
            overflow_next  = 1'b0;
        end
        else if (ctrl.append)
        begin
            if (active_vec[PATTERN_MAX-1])
            begin
                overflow_next = 1'b1;
            end
        end
        else if (ctrl.text)
        begin
            live_last_next = adv_vec[PATTERN_MAX-1];
        end
        else if (ctrl.finish)
        begin
            live_last_next = 1'b0;
        end
    end

    always_comb
    begin
        priority if (ctrl.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_last_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            live_last_reg <= live_last_next;
            overflow_reg  <= overflow_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            matched_reg  <= hit & ~overflow_reg;
            too_long_reg <= overflow_reg;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign matched          = matched_reg;
    assign pattern_too_long = too_long_reg;

    // in-use flags always fill from cell zero upward
    a_active_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, active_vec} + {{PATTERN_MAX{1'b0}}, 1'b1}))
        else $error("pattern cells not filled contiguously");

    // overflow only once every cell holds a symbol
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> active_vec[PATTERN_MAX-1])
        else $error("overflow flag set with free cells");

    // an accepted end-of-text transaction always yields a result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> rsp_valid_reg)
        else $error("end of text gave no result");

    // a match is never reported together with overflow
    a_no_match_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish && overflow_reg |=> !matched_reg)
        else $error("match reported with dropped pattern symbols");

endmodule : wildcard_glob_matcher
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard glob matcher. Directed tasks cover the
// empty pattern, extreme and zero symbols, star and question wildcards,
// appends and clears in the middle of a text and pattern overflow. A random
// task then loads mostly short patterns, some overflowing, and streams texts
// built to match them, some spoiled, mixed with stray transactions. A local
// model predicts every end-of-text result; a monitor compares each in order.
// ----------------------------------------------------------------------------
module tb;
    import wgm_pkg::*;

    localparam logic [SYM_W-1:0] SYM_A = SYM_W'(97);
    localparam logic [SYM_W-1:0] SYM_B = SYM_W'(98);

    typedef struct packed {
        logic matched;
        logic too_long;
    } verdict_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    logic [1:0]       action = ACT_CLEAR;
    logic [SYM_W-1:0] symbol = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    logic             matched;
    logic             pattern_too_long;

    // local copy of the matcher state
    logic [SYM_W-1:0]     pat_sym [PATTERN_MAX];
    int unsigned          pat_len = 0;
    logic                 pat_overflow = 1'b0;
    logic [PATTERN_MAX:0] live_set = (PATTERN_MAX+1)'(1);

    verdict_t    verdicts_due[$];
    verdict_t    head;
    int unsigned items_sent = 0;
    int unsigned errors = 0;
    bit          idle_on = 1'b1;

    wildcard_glob_matcher uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .action           (action),
        .symbol           (symbol),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .matched          (matched),
        .pattern_too_long (pattern_too_long)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $realtime, what);
        errors++;
    endtask

    // live positions extended through stars of the current pattern
    function automatic logic [PATTERN_MAX:0] star_closed(logic [PATTERN_MAX:0] v);
        logic [PATTERN_MAX:0] r;
        r = v;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (i < pat_len && r[i] && pat_sym[i] == SYM_STAR)
                r[i+1] = 1'b1;
        end
        return r;
    endfunction

    // advance the local state by one accepted transaction
    task automatic predict_glob(act_t a, logic [SYM_W-1:0] s);
        logic [PATTERN_MAX:0] cur;
        logic [PATTERN_MAX:0] nxt;
        verdict_t             v;
        case (a)
            ACT_CLEAR:
            begin
                pat_len = 0;
                pat_overflow = 1'b0;
                live_set = (PATTERN_MAX+1)'(1);
            end
            ACT_APPEND:
            begin
                if (pat_len < PATTERN_MAX)
                begin
                    pat_sym[pat_len] = s;
                    pat_len++;
                end
                else
                    pat_overflow = 1'b1;
            end
            ACT_TEXT:
            begin
                cur = star_closed(live_set);
                nxt = '0;
                for (int i = 0; i < PATTERN_MAX; i++)
                begin
                    if (i < pat_len && cur[i])
                    begin
                        if (pat_sym[i] == SYM_STAR)
                            nxt[i] = 1'b1;
                        else if (pat_sym[i] == SYM_ANY || pat_sym[i] == s)
                            nxt[i+1] = 1'b1;
                    end
                end
                live_set = nxt;
            end
            default:
            begin
                cur = star_closed(live_set);
                v.matched = cur[pat_len] && !pat_overflow;
                v.too_long = pat_overflow;
                verdicts_due.push_back(v);
                live_set = (PATTERN_MAX+1)'(1);
            end
        endcase
    endtask

    // drive one transaction and wait for its acceptance
    task automatic send_item(act_t a, logic [SYM_W-1:0] s);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_valid <= 1'b1;
        action <= a;
        symbol <= s;
        @(negedge clk);
        while (req_stall)
            @(negedge clk);
        @(posedge clk);
        predict_glob(a, s);
        items_sent++;
    endtask

    function automatic logic [SYM_W-1:0] pattern_symbol();
        case ($urandom_range(0, 9))
            0, 1: return SYM_STAR;
            2: return SYM_ANY;
            3: return SYM_W'($urandom);
            4: return '0;
            default: return SYM_A + SYM_W'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] text_symbol();
        case ($urandom_range(0, 9))
            0: return SYM_W'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? SYM_STAR : SYM_ANY;
            2: return '0;
            default: return SYM_A + SYM_W'($urandom_range(0, 2));
        endcase
    endfunction

    // empty pattern takes only the empty text
    task automatic test_empty_pattern();
        send_item(ACT_CLEAR, '0);
        send_item(ACT_END, '0);
        send_item(ACT_TEXT, SYM_A);
        send_item(ACT_END, '1);
    endtask

    // symbol zero and all-ones are plain symbols on both sides
    task automatic test_extreme_symbols();
        send_item(ACT_CLEAR, '1);
        send_item(ACT_APPEND, '0);
        send_item(ACT_APPEND, '1);
        send_item(ACT_TEXT, '0);
        send_item(ACT_TEXT, '1);
        send_item(ACT_END, '0);
        send_item(ACT_TEXT, '0);
        send_item(ACT_END, '0);
    endtask

    // star runs, question marks and chained stars
    task automatic test_wildcards();
        send_item(ACT_CLEAR, '0);
        send_item(ACT_APPEND, SYM_STAR);
        send_item(ACT_APPEND, SYM_STAR);
        send_item(ACT_APPEND, SYM_ANY);
        send_item(ACT_APPEND, SYM_B);
        send_item(ACT_TEXT, SYM_A);
        send_item(ACT_TEXT, SYM_B);
        send_item(ACT_TEXT, SYM_B);
        send_item(ACT_END, '0);
        send_item(ACT_TEXT, SYM_B);
        send_item(ACT_END, '0);
        send_item(ACT_TEXT, SYM_STAR);
        send_item(ACT_TEXT, SYM_B);
        send_item(ACT_END, '0);
    endtask

    // pattern edits in the middle of a text
    task automatic test_midtext_edits();
        send_item(ACT_CLEAR, '0);
        send_item(ACT_APPEND, SYM_A);
        send_item(ACT_TEXT, SYM_A);
        send_item(ACT_APPEND, SYM_STAR);
        send_item(ACT_TEXT, SYM_B);
        send_item(ACT_END, '0);
        send_item(ACT_TEXT, SYM_B);
        send_item(ACT_CLEAR, '0);
        send_item(ACT_END, '0);
    endtask

    // a full pattern drops further symbols until a clear
    task automatic test_pattern_overflow();
        send_item(ACT_CLEAR, '0);
        repeat (PATTERN_MAX)
            send_item(ACT_APPEND, SYM_STAR);
        send_item(ACT_END, '0);
        send_item(ACT_APPEND, SYM_A);
        send_item(ACT_END, '0);
        send_item(ACT_APPEND, SYM_B);
        send_item(ACT_TEXT, SYM_A);
        send_item(ACT_END, '0);
        send_item(ACT_CLEAR, '0);
        send_item(ACT_END, '0);
    endtask

    // random patterns with texts built to match, some spoiled, plus stray traffic
    task automatic test_random_texts(int unsigned target);
        logic [SYM_W-1:0] pat_q[$];
        logic [SYM_W-1:0] text_q[$];
        int unsigned      plen;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(act_t'($urandom_range(0, 3)), SYM_W'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0: plen = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4);
                    1: plen = $urandom_range(9, PATTERN_MAX);
                    default: plen = $urandom_range(0, 8);
                endcase
                pat_q.delete();
                send_item(ACT_CLEAR, SYM_W'($urandom));
                repeat (plen)
                begin
                    pat_q.push_back(pattern_symbol());
                    send_item(ACT_APPEND, pat_q[$]);
                end
                repeat ($urandom_range(1, 4))
                begin
                    text_q.delete();
                    foreach (pat_q[j])
                    begin
                        if (pat_q[j] == SYM_STAR)
                            repeat ($urandom_range(0, 3)) text_q.push_back(text_symbol());
                        else if (pat_q[j] == SYM_ANY)
                            text_q.push_back(text_symbol());
                        else
                            text_q.push_back(pat_q[j]);
                    end
                    // spoil some of the texts
                    case ($urandom_range(0, 5))
                        0:
                        begin
                            if (text_q.size() > 0)
                                text_q[$urandom_range(0, text_q.size() - 1)] = text_symbol();
                        end
                        1: text_q.push_back(text_symbol());
                        2:
                        begin
                            if (text_q.size() > 0)
                                text_q.delete($urandom_range(0, text_q.size() - 1));
                        end
                        default: ;
                    endcase
                    foreach (text_q[j])
                    begin
                        if ($urandom_range(0, 39) == 0)
                            send_item(ACT_APPEND, pattern_symbol());
                        send_item(ACT_TEXT, text_q[j]);
                    end
                    send_item(ACT_END, SYM_W'($urandom));
                end
            end
        end
    endtask

    // result side back-pressure in bursts
    always
    begin
        @(posedge clk);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clk);
            rsp_stall <= 1'b0;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(negedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (verdicts_due.size() == 0)
                report_mismatch("result with nothing pending");
            else
            begin
                head = verdicts_due.pop_front();
                if (matched !== head.matched)
                    report_mismatch($sformatf("matched %b, predicted %b",
                                              matched, head.matched));
                if (pattern_too_long !== head.too_long)
                    report_mismatch($sformatf("pattern_too_long %b, predicted %b",
                                              pattern_too_long, head.too_long));
            end
        end
    end

    initial
    begin
        int unsigned waited;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pattern();
        test_extreme_symbols();
        test_wildcards();
        test_midtext_edits();
        test_pattern_overflow();
        test_random_texts(items_sent + 1500);
        // closing stretch at full rate
        idle_on = 1'b0;
        test_random_texts(items_sent + 250);
        req_valid <= 1'b0;
        waited = 0;
        while (verdicts_due.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        if (verdicts_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdicts_due.size()));
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // hard stop in case a handshake hangs
    initial
    begin
        #4_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
